// ----- design/bmwq_pkg.sv -----
// shared types, widths and codes of the best-match wait queue
package bmwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_TOKENS      = 4;
  localparam int COUNT_BITS      = 8;
  localparam int RANK_BITS       = 8;
  localparam int REQ_BITS        = 2;
  localparam int STATUS_BITS     = 2;

  localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
  localparam int TOP_MAX    = COUNT_MAX * NUM_TOKENS;
  localparam int TOP_BITS   = $clog2(TOP_MAX + 1);
  localparam int SCORE_BITS = $clog2(NUM_TOKENS * (TOP_MAX + COUNT_MAX) + 1);

  localparam logic [REQ_BITS-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_SERVE  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_DELETE = 2'd2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NONE      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef logic [NUM_TOKENS-1:0][COUNT_BITS-1:0] counts_t;

  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    counts_t              counts;
  } entry_t;

endpackage

// ----- design/bmwq_if.sv -----
// request and response channel interfaces of the best-match wait queue
interface bmwq_req_if;
  import bmwq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_BITS-1:0]   req_type;
  logic [RANK_BITS-1:0]  proc_rank;
  logic [COUNT_BITS-1:0] count_0;
  logic [COUNT_BITS-1:0] count_1;
  logic [COUNT_BITS-1:0] count_2;
  logic [COUNT_BITS-1:0] count_3;

  modport source (output valid, req_type, proc_rank, count_0, count_1, count_2, count_3,
                  input ready);
  modport sink   (input valid, req_type, proc_rank, count_0, count_1, count_2, count_3,
                  output ready);
endinterface

interface bmwq_rsp_if;
  import bmwq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [RANK_BITS-1:0]   served_rank;
  logic [COUNT_BITS-1:0]  served_count_0;
  logic [COUNT_BITS-1:0]  served_count_1;
  logic [COUNT_BITS-1:0]  served_count_2;
  logic [COUNT_BITS-1:0]  served_count_3;
  logic [SCORE_BITS-1:0]  served_score;

  modport source (output valid, status, served_rank, served_count_0, served_count_1,
                  served_count_2, served_count_3, served_score, input ready);
  modport sink   (input valid, status, served_rank, served_count_0, served_count_1,
                  served_count_2, served_count_3, served_score, output ready);
endinterface

// ----- design/bmwq_score.sv -----
// match score of one stored entry against the reference vector
module bmwq_score (
  input  bmwq_pkg::counts_t                  ref_counts,
  input  logic [bmwq_pkg::TOP_BITS-1:0]      top,
  input  bmwq_pkg::counts_t                  ent_counts,
  output logic [bmwq_pkg::SCORE_BITS-1:0]    score
);
  import bmwq_pkg::*;

  logic [SCORE_BITS-1:0] acc;
  logic [COUNT_BITS-1:0] small_cnt;

  always_comb begin
    acc       = '0;
    small_cnt = '0;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (ref_counts[t] != '0 && ent_counts[t] != '0) begin
        small_cnt = (ref_counts[t] <= ent_counts[t]) ? ref_counts[t] : ent_counts[t];
        acc = acc + SCORE_BITS'(top) + SCORE_BITS'(small_cnt);
      end
    end
    score = acc;
  end

endmodule

// ----- design/best_match_wait_queue.sv -----
// top level of the best-match wait queue
//
// usage
//   req channel carries one request: append (rank + counts stored at the tail),
//   serve (counts are the reference vector; the best-scoring entry, nearest the
//   head on ties, is removed and returned) or delete (first entry with the rank
//   is removed). rsp channel returns exactly one response per request.
//   entries live in a single-port-write, registered-read memory; a request is
//   taken only while the sequencer is idle (req.ready is low otherwise).
// sequence, from the accepting edge to rsp.valid
//   append and the undefined type go straight to loading the response.
//   serve and delete: a scan of the occupied entries, then,
//   when an entry is removed, a compaction that moves the later entries up
//   one place, then the response is loaded.
//   no new request is taken before the last one's response is loaded; the
//   sequencer is idle again, ready for the next request, as rsp.valid rises.
// reset: the queue comes up empty; no clearing pass, entries are only read
//   below the occupancy count.
// stall: a response waits in the output register while the next request is
//   accepted and worked on; that response is held until the register is taken.
module best_match_wait_queue #(
  parameter int QUEUE_DEPTH = bmwq_pkg::QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bmwq_req_if.sink   req,
  bmwq_rsp_if.source rsp
);
  import bmwq_pkg::*;

  localparam int ADDR_BITS = $clog2(QUEUE_DEPTH);
  localparam int OCC_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // queue storage and its read pipeline
  entry_t                mem [QUEUE_DEPTH];
  entry_t                rd_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic                  rd_issue;
  logic                  rd_pend;
  logic [ADDR_BITS-1:0]  rd_pos;
  logic [OCC_BITS-1:0]   rd_ptr;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  entry_t                wr_data;
  logic [OCC_BITS-1:0]   occ;

  // request held during the scan
  logic [REQ_BITS-1:0]   kind_q;
  logic [RANK_BITS-1:0]  rank_q;
  counts_t               ref_q;
  logic [TOP_BITS-1:0]   top_q;
  counts_t               req_counts;
  logic [COUNT_BITS-1:0] req_max;
  logic [TOP_BITS-1:0]   req_top;

  // running best and the result
  logic                  found;
  logic [ADDR_BITS-1:0]  best_pos;
  logic [SCORE_BITS-1:0] best_score;
  logic [SCORE_BITS-1:0] score;
  entry_t                best_entry;
  status_t               res_status;

  // output register
  logic                  out_valid;
  status_t               out_status;
  entry_t                out_entry;
  logic [SCORE_BITS-1:0] out_score;
  logic                  out_load;
  logic                  scan_done;

  assign req_counts[0] = req.count_0;
  assign req_counts[1] = req.count_1;
  assign req_counts[2] = req.count_2;
  assign req_counts[3] = req.count_3;

  // top = largest reference count times the vector length
  always_comb begin
    req_max = '0;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (req_counts[t] > req_max) req_max = req_counts[t];
    end
    req_top = TOP_BITS'(req_max) * TOP_BITS'(NUM_TOKENS);
  end

  // shared scoring unit, fed by the memory read data
  bmwq_score u_score (
    .ref_counts (ref_q),
    .top        (top_q),
    .ent_counts (rd_data.counts),
    .score      (score)
  );

  assign req.ready = (state == S_IDLE);
  assign rd_issue  = (state == S_SCAN || state == S_SHIFT) && (rd_ptr < occ);
  assign rd_addr   = rd_ptr[ADDR_BITS-1:0];
  assign scan_done = (rd_ptr >= occ) && !rd_pend;
  assign out_load  = (state == S_FINISH) && (!out_valid || rsp.ready);

  // write port: append at the tail, or copy one entry up during compaction
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = occ[ADDR_BITS-1:0];
    wr_data = '{rank: req.proc_rank, counts: req_counts};
    if (state == S_IDLE && req.valid && req.req_type == REQ_APPEND &&
        occ != OCC_BITS'(QUEUE_DEPTH)) begin
      wr_en = 1'b1;
    end
    if (state == S_SHIFT && rd_pend) begin
      wr_en   = 1'b1;
      wr_addr = rd_pos - ADDR_BITS'(1);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      rd_pend <= 1'b0;
      rd_ptr  <= '0;
      found   <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      rd_pos  <= rd_ptr[ADDR_BITS-1:0];
      if (rd_issue) rd_ptr <= rd_ptr + OCC_BITS'(1);

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_q     <= req.req_type;
            rank_q     <= req.proc_rank;
            ref_q      <= req_counts;
            top_q      <= req_top;
            best_score <= '0;
            best_pos   <= '0;
            found      <= 1'b0;
            rd_ptr     <= '0;
            unique case (req.req_type)
              REQ_APPEND: begin
                if (occ == OCC_BITS'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  occ        <= occ + OCC_BITS'(1);
                  res_status <= ST_OK;
                end
                state <= S_FINISH;
              end
              REQ_SERVE, REQ_DELETE: state <= S_SCAN;
              default: begin
                res_status <= ST_NONE;
                state      <= S_FINISH;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (rd_pend) begin
            if (kind_q == REQ_SERVE) begin
              // strict compare keeps the entry nearest the head on ties
              if (score > best_score) begin
                best_score <= score;
                best_pos   <= rd_pos;
                best_entry <= rd_data;
                found      <= 1'b1;
              end
            end else if (!found && rd_data.rank == rank_q) begin
              best_pos <= rd_pos;
              found    <= 1'b1;
            end
          end
          if (scan_done) begin
            if (found) begin
              res_status <= ST_OK;
              rd_ptr     <= OCC_BITS'(best_pos) + OCC_BITS'(1);
              state      <= S_SHIFT;
            end else begin
              res_status <= (kind_q == REQ_SERVE) ? ST_NONE : ST_NOT_FOUND;
              state      <= S_FINISH;
            end
          end
        end

        S_SHIFT: begin
          // later entries moved up one place; drop the tail
          if (scan_done) begin
            occ   <= occ - OCC_BITS'(1);
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_load) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      if (found && kind_q == REQ_SERVE) begin
        out_entry <= best_entry;
        out_score <= best_score;
      end else begin
        out_entry <= '0;
        out_score <= '0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.served_rank    = out_entry.rank;
  assign rsp.served_count_0 = out_entry.counts[0];
  assign rsp.served_count_1 = out_entry.counts[1];
  assign rsp.served_count_2 = out_entry.counts[2];
  assign rsp.served_count_3 = out_entry.counts[3];
  assign rsp.served_score   = out_score;

  // occupancy never passes the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_BITS'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // an append that fits grows the queue by exactly one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req.valid && req.req_type == REQ_APPEND &&
     occ != OCC_BITS'(QUEUE_DEPTH)) |=> (occ == $past(occ) + OCC_BITS'(1)))
    else $error("append did not grow the queue");

  // every pending read lies below the occupancy
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (OCC_BITS'(rd_pos) < occ))
    else $error("read beyond the stored entries");

  // a served entry always carries a positive score
  a_served_score: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && found && kind_q == REQ_SERVE) |-> (best_score != '0))
    else $error("serve with zero score");

endmodule

// ----- sim/tb_best_match_wait_queue.sv -----
// testbench of the best-match wait queue: directed table, then random traffic checked
`timescale 1ns / 1ps

module tb_best_match_wait_queue;
  import bmwq_pkg::*;

  localparam int QDEPTH = 16;
  // request type three has no meaning; the block answers it like an empty serve
  localparam logic [REQ_BITS-1:0] REQ_UNDEF = 2'd3;
  localparam int PHASES = 25;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE_CYCLES = 2 * QDEPTH + 8;

  // one request as it goes into the block
  typedef struct packed {
    logic [REQ_BITS-1:0]  kind;
    logic [RANK_BITS-1:0] rank;
    counts_t              counts;
  } request_t;

  // one response as it comes out of the block
  typedef struct {
    status_t               status;
    logic [RANK_BITS-1:0]  rank;
    counts_t               counts;
    logic [SCORE_BITS-1:0] score;
  } reply_t;

  // row of the directed table; typed rows carry a hand-written response
  typedef struct {
    request_t rq;
    bit       typed;
    reply_t   want;
  } script_row_t;

  logic clk;
  logic rst;

  bmwq_req_if req_ch ();
  bmwq_rsp_if rsp_ch ();

  best_match_wait_queue #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // shadow copy of the queue, head at index 0
  entry_t waiting_q[$];
  // responses still owed by the block, oldest first
  reply_t owed_q[$];
  int     mismatches = 0;
  // when set, neither side inserts gaps or stalls
  bit     calm = 1'b0;

  always #1 clk = ~clk;

  function automatic request_t mk_req(logic [REQ_BITS-1:0] kind, int rank,
                                      int c0, int c1, int c2, int c3);
    request_t r;
    r.kind = kind;
    r.rank = rank[RANK_BITS-1:0];
    r.counts[0] = c0[COUNT_BITS-1:0];
    r.counts[1] = c1[COUNT_BITS-1:0];
    r.counts[2] = c2[COUNT_BITS-1:0];
    r.counts[3] = c3[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic reply_t mk_rep(status_t st, int rank, int c0, int c1, int c2, int c3,
                                    int score);
    reply_t r;
    r.status = st;
    r.rank = rank[RANK_BITS-1:0];
    r.counts[0] = c0[COUNT_BITS-1:0];
    r.counts[1] = c1[COUNT_BITS-1:0];
    r.counts[2] = c2[COUNT_BITS-1:0];
    r.counts[3] = c3[COUNT_BITS-1:0];
    r.score = score[SCORE_BITS-1:0];
    return r;
  endfunction

  // match score of one stored entry against a reference vector:
  // every position where both are nonzero adds top + min(ref, entry),
  // with top = largest reference count times the vector length
  function automatic int match_score(counts_t ref_vec, counts_t held);
    int top;
    int total;
    top = 0;
    total = 0;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (int'(ref_vec[t]) > top) top = int'(ref_vec[t]);
    end
    top = top * NUM_TOKENS;
    for (int t = 0; t < NUM_TOKENS; t++) begin
      if (ref_vec[t] != 0 && held[t] != 0) begin
        total += top + ((ref_vec[t] <= held[t]) ? int'(ref_vec[t]) : int'(held[t]));
      end
    end
    return total;
  endfunction

  // applies one request to the shadow queue and returns the response it owes
  function automatic reply_t apply_request(request_t rq);
    reply_t r;
    entry_t e;
    int     best;
    int     pos;
    int     s;
    r = mk_rep(ST_OK, 0, 0, 0, 0, 0, 0);
    pos = -1;
    best = 0;
    case (rq.kind)
      REQ_APPEND: begin
        if (waiting_q.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.rank = rq.rank;
          e.counts = rq.counts;
          waiting_q.push_back(e);
        end
      end
      REQ_SERVE: begin
        // strict greater-than keeps the entry nearest the head on ties
        foreach (waiting_q[i]) begin
          s = match_score(rq.counts, waiting_q[i].counts);
          if (s > best) begin
            best = s;
            pos = i;
          end
        end
        if (pos < 0) begin
          r.status = ST_NONE;
        end else begin
          r.rank = waiting_q[pos].rank;
          r.counts = waiting_q[pos].counts;
          r.score = best[SCORE_BITS-1:0];
          waiting_q.delete(pos);
        end
      end
      REQ_DELETE: begin
        foreach (waiting_q[i]) begin
          if (pos < 0 && waiting_q[i].rank == rq.rank) pos = i;
        end
        if (pos < 0) r.status = ST_NOT_FOUND;
        else waiting_q.delete(pos);
      end
      default: r.status = ST_NONE;
    endcase
    return r;
  endfunction

  // count values lean on zero, the maximum and small numbers
  function automatic int pick_count();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return 0;
    if (sel < 5) return COUNT_MAX;
    if (sel < 7) return $urandom_range(1, 15);
    return $urandom_range(0, COUNT_MAX);
  endfunction

  // random request; mix picks the weights: 0 fills, 1 drains, 2 balanced
  function automatic request_t pick_request(int mix);
    request_t rq;
    int roll;
    int append_pct;
    int serve_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      0:       begin append_pct = 80; serve_pct = 10; end
      1:       begin append_pct = 10; serve_pct = 50; end
      default: begin append_pct = 40; serve_pct = 35; end
    endcase
    rq = mk_req(REQ_APPEND, 0, pick_count(), pick_count(), pick_count(), pick_count());
    // a small rank pool keeps deletes hitting; the full range shows up too
    rq.rank = ($urandom_range(0, 3) == 0) ? RANK_BITS'($urandom_range(0, 255))
                                          : RANK_BITS'($urandom_range(0, 7));
    if (roll < append_pct) begin
      rq.kind = REQ_APPEND;
    end else if (roll < append_pct + serve_pct) begin
      rq.kind = REQ_SERVE;
    end else if (roll < 97) begin
      rq.kind = REQ_DELETE;
      if (waiting_q.size() != 0 && $urandom_range(0, 4) < 3) begin
        rq.rank = waiting_q[$urandom_range(0, waiting_q.size() - 1)].rank;
      end
    end else begin
      rq.kind = REQ_UNDEF;
      rq.rank = RANK_BITS'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  // presents one request after a random gap and waits for the block to take it;
  // valid is only lowered when a gap follows, so back-to-back requests keep it high
  task automatic issue(request_t rq, bit typed, reply_t want);
    int     gap;
    reply_t predicted;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rq.kind;
    req_ch.proc_rank <= rq.rank;
    req_ch.count_0   <= rq.counts[0];
    req_ch.count_1   <= rq.counts[1];
    req_ch.count_2   <= rq.counts[2];
    req_ch.count_3   <= rq.counts[3];
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    // the shadow queue always advances; typed rows replace what it predicts
    predicted = apply_request(rq);
    owed_q.push_back(typed ? want : predicted);
  endtask

  task automatic wait_until_answered();
    while (owed_q.size() != 0) @(posedge clk);
  endtask

  // request side: reset, directed table, then random phases
  initial begin
    script_row_t script[$];
    reply_t      idle_rep;
    clk = 1'b0;
    rst <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_APPEND;
    req_ch.proc_rank <= '0;
    req_ch.count_0   <= '0;
    req_ch.count_1   <= '0;
    req_ch.count_2   <= '0;
    req_ch.count_3   <= '0;
    idle_rep = mk_rep(ST_OK, 0, 0, 0, 0, 0, 0);

    // serve, delete and the undefined type on an empty queue
    script.push_back('{mk_req(REQ_SERVE, 0, 9, 9, 9, 9), 1'b1,
                       mk_rep(ST_NONE, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_DELETE, 5, 0, 0, 0, 0), 1'b1,
                       mk_rep(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_UNDEF, 255, 255, 255, 255, 255), 1'b1,
                       mk_rep(ST_NONE, 0, 0, 0, 0, 0, 0)});
    // field extremes on append
    script.push_back('{mk_req(REQ_APPEND, 0, 0, 0, 0, 0), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_APPEND, 255, 255, 255, 255, 255), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_APPEND, 7, 1, 0, 3, 0), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    // all-zero reference scores nothing
    script.push_back('{mk_req(REQ_SERVE, 0, 0, 0, 0, 0), 1'b1,
                       mk_rep(ST_NONE, 0, 0, 0, 0, 0, 0)});
    // full reference against the full entry gives the largest score there is
    script.push_back('{mk_req(REQ_SERVE, 0, 255, 255, 255, 255), 1'b1,
                       mk_rep(ST_OK, 255, 255, 255, 255, 255, 5100)});
    // duplicate rank, then a tie on score: the older one must win
    script.push_back('{mk_req(REQ_APPEND, 7, 0, 0, 3, 0), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_SERVE, 0, 0, 0, 3, 0), 1'b0, idle_rep});
    script.push_back('{mk_req(REQ_DELETE, 7, 0, 0, 0, 0), 1'b0, idle_rep});
    script.push_back('{mk_req(REQ_DELETE, 0, 0, 0, 0, 0), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_SERVE, 0, 1, 0, 0, 0), 1'b1,
                       mk_rep(ST_NONE, 0, 0, 0, 0, 0, 0)});
    // alternating bit patterns, then picks that each favor a different entry
    script.push_back('{mk_req(REQ_APPEND, 8'hAA, 8'h55, 8'hAA, 8'h0F, 8'hF0), 1'b1,
                       mk_rep(ST_OK, 0, 0, 0, 0, 0, 0)});
    script.push_back('{mk_req(REQ_APPEND, 8'h55, 8'hAA, 8'h55, 8'hF0, 8'h0F), 1'b0, idle_rep});
    script.push_back('{mk_req(REQ_SERVE, 0, 255, 0, 0, 0), 1'b0, idle_rep});
    script.push_back('{mk_req(REQ_SERVE, 0, 0, 1, 0, 0), 1'b0, idle_rep});
    script.push_back('{mk_req(REQ_DELETE, 8'h55, 0, 0, 0, 0), 1'b1,
                       mk_rep(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) issue(script[i].rq, script[i].typed, script[i].want);

    // hold off until the block has answered everything
    req_ch.valid <= 1'b0;
    wait_until_answered();

    // phase 0 fills the queue so appends run into a full queue early;
    // every fifth phase runs with no gaps or stalls on either side
    for (int p = 0; p < PHASES; p++) begin
      calm = (p % 5 == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) issue(pick_request(p % 3), 1'b0, idle_rep);
      req_ch.valid <= 1'b0;
      wait_until_answered();
    end
    calm = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("best_match_wait_queue: match");
    end else begin
      $display("best_match_wait_queue: mismatch");
    end
    $finish;
  end

  // response side: random stall per response, then compare with the oldest owed one
  initial begin
    int     stall;
    reply_t got;
    reply_t want;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1 || rst !== 1'b0);
      got.status = status_t'(rsp_ch.status);
      got.rank = rsp_ch.served_rank;
      got.counts[0] = rsp_ch.served_count_0;
      got.counts[1] = rsp_ch.served_count_1;
      got.counts[2] = rsp_ch.served_count_2;
      got.counts[3] = rsp_ch.served_count_3;
      got.score = rsp_ch.served_score;
      if (owed_q.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatches++;
        end
        if (got.rank !== want.rank) begin
          $error("served_rank: expected %0d, got %0d", want.rank, got.rank);
          mismatches++;
        end
        for (int t = 0; t < NUM_TOKENS; t++) begin
          if (got.counts[t] !== want.counts[t]) begin
            $error("served_count_%0d: expected %0d, got %0d", t, want.counts[t],
                   got.counts[t]);
            mismatches++;
          end
        end
        if (got.score !== want.score) begin
          $error("served_score: expected %0d, got %0d", want.score, got.score);
          mismatches++;
        end
      end
    end
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #2000000;
    $display("best_match_wait_queue: mismatch");
    $finish;
  end

endmodule
